// ===== hdl/ast_pkg.sv =====
// Shared types, character codes and character-class helpers for the assembler
// source tokenizer. No dependencies; imported by every module in hdl/.
`timescale 1ns / 1ps

package ast_pkg;

    localparam int OUTQ_DEPTH_DEF = 4;

    localparam logic [15:0] LINE_FIRST = 16'd1;

    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_NL    = 8'h0A;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_HASH  = 8'h23;
    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_SEMI  = 8'h3B;
    localparam logic [7:0] CH_EQ    = 8'h3D;

    typedef enum logic [2:0] {
        MODE_IDLE    = 3'd0,
        MODE_COMMENT = 3'd1,
        MODE_WORD    = 3'd2,
        MODE_STRING  = 3'd3,
        MODE_QUOTE   = 3'd4,
        MODE_COLON   = 3'd5
    } t_mode;

    typedef enum logic [3:0] {
        TT_CHAR    = 4'd0,
        TT_SYMBOL  = 4'd1,
        TT_LABEL   = 4'd2,
        TT_GLABEL  = 4'd3,
        TT_EQUATE  = 4'd4,
        TT_INTEGER = 4'd5,
        TT_STRING  = 4'd6,
        TT_EOL     = 4'd7,
        TT_EOF     = 4'd8
    } t_tok;

    typedef enum logic {
        IK_TEXT = 1'b0,
        IK_END  = 1'b1
    } t_ikind;

    typedef struct packed {
        t_ikind             item_kind;
        logic [7:0]         text_byte;
        t_tok               token_type;
        logic signed [15:0] int_value;
        logic [15:0]        line_count;
        logic               begins_line;
        logic               last;
    } t_res;

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= "0") && (c <= "9");
    endfunction

    function automatic logic is_letter(input logic [7:0] c);
        return ((c >= "A") && (c <= "Z")) || ((c >= "a") && (c <= "z"));
    endfunction

    function automatic logic word_start(input logic [7:0] c);
        return is_digit(c) || is_letter(c) || (c == CH_MINUS) || (c == ".") ||
               (c == "%") || (c == "?") || (c == CH_HASH) || (c == "(") || (c == "&");
    endfunction

    function automatic logic word_more(input logic [7:0] c);
        return is_digit(c) || is_letter(c) || (c == CH_MINUS) || (c == CH_HASH) ||
               (c == "(") || (c == "!") || (c == "?") || (c == "%") || (c == ".") ||
               (c == CH_DOLLAR) || (c == 8'h27) || (c == "/") || (c == "&");
    endfunction

endpackage

// ===== hdl/ast_scan.sv =====
// Scanner state and per-byte decode: turns one source byte or end-of-file
// into zero, one or two result items. Depends on ast_pkg.
`timescale 1ns / 1ps

module ast_scan
    import ast_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_fire,
    input  logic       i_kind,
    input  logic [7:0] i_char,
    output t_res       o_res0,
    output t_res       o_res1,
    output logic [1:0] o_count
);

    t_mode       r_mode, n_mode;
    logic        r_numeric, n_numeric;
    logic        r_negative, n_negative;
    logic [15:0] r_acc, n_acc;
    logic [15:0] r_line, n_line;
    logic        r_ls, n_ls;

    logic        w_more, w_start, w_digit, w_sep_eq, w_sep_colon;
    logic        w_begin;
    logic [15:0] w_acc10, w_int;
    logic        pre_v, beg_v;
    t_res        pre, beg, res_close, res_blank;

    assign w_more      = word_more(i_char);
    assign w_start     = word_start(i_char);
    assign w_digit     = is_digit(i_char);
    assign w_sep_eq    = !r_numeric && r_ls && (i_char == CH_EQ);
    assign w_sep_colon = !r_numeric && r_ls && (i_char == CH_COLON);
    // acc * 10 + digit, wrapping
    assign w_acc10 = (r_acc << 3) + (r_acc << 1) + {8'd0, i_char - CH_ZERO};
    assign w_int   = r_negative ? (16'd0 - r_acc) : r_acc;

    // the byte is rescanned as the start of a new token
    always_comb begin
        w_begin = 1'b0;
        if (!i_kind) begin
            unique case (r_mode)
                MODE_COMMENT: w_begin = (i_char == CH_NL);
                MODE_WORD:    w_begin = !w_more && !w_sep_eq && !w_sep_colon;
                MODE_STRING:  w_begin = 1'b0;
                MODE_QUOTE:   w_begin = (i_char != CH_QUOTE);
                MODE_COLON:   w_begin = (i_char != CH_COLON);
                default:      w_begin = 1'b1;
            endcase
        end
    end

    // next state
    always_comb begin
        n_mode     = r_mode;
        n_numeric  = r_numeric;
        n_negative = r_negative;
        n_acc      = r_acc;
        n_line     = r_line;
        n_ls       = r_ls;
        if (i_kind) begin
            n_mode     = MODE_IDLE;
            n_numeric  = 1'b0;
            n_negative = 1'b0;
            n_acc      = 16'd0;
            n_line     = LINE_FIRST;
            n_ls       = 1'b1;
        end else begin
            unique case (r_mode)
                MODE_COMMENT: if (i_char == CH_NL) n_mode = MODE_IDLE;
                MODE_WORD: begin
                    if (w_more) begin
                        if (w_digit) n_acc = w_acc10;
                        else         n_numeric = 1'b0;
                    end else if (w_sep_colon) begin
                        n_mode = MODE_COLON;
                    end else begin
                        n_mode = MODE_IDLE;
                        if (!w_sep_eq && !r_numeric) n_ls = 1'b0;
                    end
                end
                MODE_STRING: begin
                    if (i_char == CH_QUOTE) n_mode = MODE_QUOTE;
                    else if (i_char == CH_NL) n_line = r_line + 16'd1;
                end
                MODE_QUOTE: begin
                    n_mode = (i_char == CH_QUOTE) ? MODE_STRING : MODE_IDLE;
                end
                MODE_COLON: n_mode = MODE_IDLE;
                default:    n_mode = MODE_IDLE;
            endcase
            if (w_begin) begin
                if (i_char == CH_SPACE || i_char == CH_TAB) begin
                    n_mode = MODE_IDLE;
                end else if (i_char == CH_SEMI) begin
                    n_mode = MODE_COMMENT;
                end else if (i_char == CH_NL) begin
                    n_line = r_line + 16'd1;
                    n_ls   = 1'b1;
                end else if (w_start) begin
                    n_mode     = MODE_WORD;
                    n_numeric  = w_digit || (i_char == CH_MINUS);
                    n_negative = (i_char == CH_MINUS);
                    n_acc      = w_digit ? {8'd0, i_char - CH_ZERO} : 16'd0;
                end else if (i_char == CH_QUOTE) begin
                    n_mode = MODE_STRING;
                end
            end
        end
    end

    // result items; every item of one step carries the old line number
    always_comb begin
        res_blank = '{item_kind: IK_TEXT, text_byte: 8'd0, token_type: TT_CHAR,
                      int_value: 16'sd0, line_count: r_line, begins_line: 1'b0,
                      last: 1'b0};
        res_close = res_blank;
        res_close.item_kind = IK_END;
        if (r_numeric) begin
            res_close.token_type = TT_INTEGER;
            res_close.int_value  = w_int;
        end else begin
            res_close.token_type  = TT_SYMBOL;
            res_close.begins_line = r_ls;
        end

        pre_v = 1'b0;
        pre   = res_blank;
        beg_v = 1'b0;
        beg   = res_blank;
        if (i_kind) begin
            unique case (r_mode) inside
                MODE_WORD: begin
                    pre_v = 1'b1;
                    pre   = res_close;
                end
                MODE_STRING, MODE_QUOTE: begin
                    pre_v = 1'b1;
                    pre.item_kind  = IK_END;
                    pre.token_type = TT_STRING;
                end
                MODE_COLON: begin
                    pre_v = 1'b1;
                    pre.item_kind   = IK_END;
                    pre.token_type  = TT_LABEL;
                    pre.begins_line = 1'b1;
                end
                default: pre_v = 1'b0;
            endcase
            beg_v = 1'b1;
            beg.item_kind  = IK_END;
            beg.token_type = TT_EOF;
        end else begin
            unique case (r_mode)
                MODE_WORD: begin
                    if (w_more) begin
                        pre_v = 1'b1;
                        pre.text_byte = i_char;
                    end else if (w_sep_eq) begin
                        pre_v = 1'b1;
                        pre.item_kind   = IK_END;
                        pre.token_type  = TT_EQUATE;
                        pre.begins_line = 1'b1;
                    end else if (!w_sep_colon) begin
                        pre_v = 1'b1;
                        pre   = res_close;
                    end
                end
                MODE_STRING: begin
                    if (i_char != CH_QUOTE) begin
                        pre_v = 1'b1;
                        pre.text_byte = i_char;
                    end
                end
                MODE_QUOTE: begin
                    pre_v = 1'b1;
                    if (i_char == CH_QUOTE) begin
                        pre.text_byte = i_char;
                    end else begin
                        pre.item_kind  = IK_END;
                        pre.token_type = TT_STRING;
                    end
                end
                MODE_COLON: begin
                    pre_v = 1'b1;
                    pre.item_kind   = IK_END;
                    pre.token_type  = (i_char == CH_COLON) ? TT_GLABEL : TT_LABEL;
                    pre.begins_line = 1'b1;
                end
                default: pre_v = 1'b0;
            endcase
            if (w_begin) begin
                if (i_char == CH_NL) begin
                    beg_v = 1'b1;
                    beg.item_kind  = IK_END;
                    beg.token_type = TT_EOL;
                end else if (w_start) begin
                    beg_v = 1'b1;
                    beg.text_byte = i_char;
                end else if (i_char != CH_SPACE && i_char != CH_TAB &&
                             i_char != CH_SEMI && i_char != CH_QUOTE) begin
                    beg_v = 1'b1;
                    beg.item_kind = IK_END;
                    beg.text_byte = i_char;
                end
            end
        end

        if (pre_v) begin
            o_res0  = pre;
            o_res1  = beg;
            o_count = beg_v ? 2'd2 : 2'd1;
        end else begin
            o_res0  = beg;
            o_res1  = res_blank;
            o_count = {1'b0, beg_v};
        end
        o_res0.last = (o_count == 2'd1);
        o_res1.last = 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode     <= MODE_IDLE;
            r_numeric  <= 1'b0;
            r_negative <= 1'b0;
            r_acc      <= 16'd0;
            r_line     <= LINE_FIRST;
            r_ls       <= 1'b1;
        end else if (i_fire) begin
            r_mode     <= n_mode;
            r_numeric  <= n_numeric;
            r_negative <= n_negative;
            r_acc      <= n_acc;
            r_line     <= n_line;
            r_ls       <= n_ls;
        end
    end

endmodule

// ===== hdl/ast_outq.sv =====
// Result queue: takes up to two result items per cycle, hands out one.
// Depends on ast_pkg.
`timescale 1ns / 1ps

module ast_outq
    import ast_pkg::*;
#(
    parameter int DEPTH = OUTQ_DEPTH_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic [1:0] i_push,
    input  t_res       i_res0,
    input  t_res       i_res1,
    input  logic       i_pop,
    output logic       o_room,
    output logic       o_valid,
    output t_res       o_res
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_IDX = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] ROOM_MAX = CNT_W'(DEPTH - 2);

    t_res             mem [DEPTH];
    logic [PTR_W-1:0] r_head, n_head, r_tail, n_tail, w_tail1;
    logic [CNT_W-1:0] r_cnt, n_cnt;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        return (p == LAST_IDX) ? '0 : p + PTR_W'(1);
    endfunction

    assign w_tail1 = ptr_inc(r_tail);
    assign o_room  = (r_cnt <= ROOM_MAX);
    assign o_valid = (r_cnt != '0);
    assign o_res   = mem[r_head];

    always_comb begin
        n_head = i_pop ? ptr_inc(r_head) : r_head;
        case (i_push)
            2'd1:    n_tail = w_tail1;
            2'd2:    n_tail = ptr_inc(w_tail1);
            default: n_tail = r_tail;
        endcase
        n_cnt = r_cnt + CNT_W'(i_push) - CNT_W'(i_pop);
    end

    always_ff @(posedge i_clk) begin
        if (i_push != 2'd0) mem[r_tail] <= i_res0;
        if (i_push == 2'd2) mem[w_tail1] <= i_res1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head <= '0;
            r_tail <= '0;
            r_cnt  <= '0;
        end else begin
            r_head <= n_head;
            r_tail <= n_tail;
            r_cnt  <= n_cnt;
        end
    end

endmodule

// ===== hdl/assembler_source_tokenizer.sv =====
// Top level of the assembler source tokenizer: input register, scanner and
// result queue. Depends on ast_pkg, ast_scan and ast_outq.
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+-------------------------------------
//  input   | in        | i_valid / o_stall  | i_kind, i_char_in
//  result  | out       | o_valid / i_stall  | o_item_kind, o_text_byte, o_token_type,
//          |           |                    | o_int_value, o_line_count,
//          |           |                    | o_begins_line, o_last
//
// One input byte per cycle while the queue has room: a byte waits in the input
// register, is scanned there and its results land in the result queue.
// A byte giving two results drains at one result per cycle unless stalled; the
// input side stalls when the queue has fewer than two free slots.
// Results leave the queue one per cycle; a stalled result holds.
// Reset returns the scanner to between-tokens, line 1, at line start, and
// empties the queue.
`timescale 1ns / 1ps

module assembler_source_tokenizer
    import ast_pkg::*;
#(
    parameter int OUTQ_DEPTH = OUTQ_DEPTH_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic               i_kind,
    input  logic [7:0]         i_char_in,
    output logic               o_valid,
    input  logic               i_stall,
    output logic               o_item_kind,
    output logic [7:0]         o_text_byte,
    output logic [3:0]         o_token_type,
    output logic signed [15:0] o_int_value,
    output logic [15:0]        o_line_count,
    output logic               o_begins_line,
    output logic               o_last
);

    logic       r_in_valid;
    logic       r_kind;
    logic [7:0] r_char;
    logic       w_room, w_fire, w_accept;
    logic [1:0] w_count;
    t_res       w_res0, w_res1, w_out;

    assign w_fire   = r_in_valid && w_room;
    assign o_stall  = r_in_valid && !w_room;
    assign w_accept = i_valid && !o_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_accept) begin
            r_in_valid <= 1'b1;
        end else if (w_fire) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_kind <= i_kind;
            r_char <= i_char_in;
        end
    end

    ast_scan u_scan (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (w_fire),
        .i_kind  (r_kind),
        .i_char  (r_char),
        .o_res0  (w_res0),
        .o_res1  (w_res1),
        .o_count (w_count)
    );

    ast_outq #(
        .DEPTH (OUTQ_DEPTH)
    ) u_outq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_fire ? w_count : 2'd0),
        .i_res0  (w_res0),
        .i_res1  (w_res1),
        .i_pop   (o_valid && !i_stall),
        .o_room  (w_room),
        .o_valid (o_valid),
        .o_res   (w_out)
    );

    assign o_item_kind   = w_out.item_kind;
    assign o_text_byte   = w_out.text_byte;
    assign o_token_type  = w_out.token_type;
    assign o_int_value   = w_out.int_value;
    assign o_line_count  = w_out.line_count;
    assign o_begins_line = w_out.begins_line;
    assign o_last        = w_out.last;

endmodule
